// File: hdl/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg
// Types, constants and AES-256 round functions shared by the layer cipher.
// ----------------------------------------------------------------------------
package aesctr_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int KEY_WORDS   = 4;
   localparam int BLOCK_BYTES = 16;
   localparam int ROUNDS      = 14;

   typedef logic [15:0][7:0] block_type;  // byte 0 at index 15

   // item passed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       too_long;
      logic [3:0] pos;
   } entry_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd1:    r = 8'h01;
         3'd2:    r = 8'h02;
         3'd3:    r = 8'h04;
         3'd4:    r = 8'h08;
         3'd5:    r = 8'h10;
         3'd6:    r = 8'h20;
         3'd7:    r = 8'h40;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // sub bytes, shift rows and, except in the final round, mix columns
   function automatic block_type enc_round(input block_type s, input logic final_rnd);
      block_type t;
      block_type u;
      block_type m;
      logic [7:0] a0, a1, a2, a3, x;
      for (int i = 0; i < 16; i++) begin
         t[15-i] = SBOX[s[15-i]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            u[15-(i+4*c)] = t[15-(i+4*((c+i)%4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = u[15-4*c];
         a1 = u[14-4*c];
         a2 = u[13-4*c];
         a3 = u[12-4*c];
         x  = a0 ^ a1 ^ a2 ^ a3;
         m[15-4*c] = a0 ^ x ^ xt(a0 ^ a1);
         m[14-4*c] = a1 ^ x ^ xt(a1 ^ a2);
         m[13-4*c] = a2 ^ x ^ xt(a2 ^ a3);
         m[12-4*c] = a3 ^ x ^ xt(a3 ^ a0);
      end
      return final_rnd ? u : m;
   endfunction

   // round key rn from round keys rn-2 and rn-1
   function automatic logic [127:0] next_key(input logic [127:0] kp, input logic [127:0] kc,
                                             input logic [3:0] rn);
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      if (!rn[0]) begin
         t = {SBOX[kc[23:16]] ^ rcon(rn[3:1]), SBOX[kc[15:8]], SBOX[kc[7:0]], SBOX[kc[31:24]]};
      end else begin
         t = {SBOX[kc[31:24]], SBOX[kc[23:16]], SBOX[kc[15:8]], SBOX[kc[7:0]]};
      end
      w0 = kp[127:96] ^ t;
      w1 = kp[95:64] ^ w0;
      w2 = kp[63:32] ^ w1;
      w3 = kp[31:0] ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

// File: hdl/aesctr_if.sv
// ----------------------------------------------------------------------------
// aesctr channel interfaces
// Valid/ready channels for input bytes, result bytes and key register writes.
// ----------------------------------------------------------------------------
interface aesctr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface aesctr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_layer;
   logic       too_long;
   modport source (output valid, output out_byte, output end_of_layer, output too_long,
                   input ready);
   modport sink (input valid, input out_byte, input end_of_layer, input too_long,
                 output ready);
endinterface

interface aesctr_csr_if;
   logic                                valid;
   logic                                ready;
   logic [aesctr_pkg::CSR_INDEX_W-1:0]  index;
   logic [63:0]                         data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/aesctr_front.sv
// ----------------------------------------------------------------------------
// aesctr_front
// Takes input bytes, tracks layer position and queues classified items.
// ----------------------------------------------------------------------------
module aesctr_front #(
   parameter int MAX_LAYER_BYTES = 256,
   parameter int SEEN_W          = 9,
   parameter int BLK_W           = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   aesctr_req_if.sink            req_chan,
   output logic                  q_valid,
   output aesctr_pkg::entry_type q_entry,
   output logic [BLK_W-1:0]      q_blk,
   input  logic                  q_pop
);

   logic [SEEN_W-1:0]     seen_ff, seen_in;
   aesctr_pkg::entry_type ent_ff [2];
   logic [BLK_W-1:0]      blk_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  push;
   logic                  over;
   logic [SEEN_W-5:0]     seen_blk;
   aesctr_pkg::entry_type new_ent;

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign over           = (seen_ff == SEEN_W'(MAX_LAYER_BYTES));
   assign seen_blk       = seen_ff[SEEN_W-1:4];

   always_comb begin
      new_ent.data_byte = req_chan.data_byte;
      new_ent.last_byte = req_chan.last_byte;
      new_ent.too_long  = over;
      new_ent.pos       = seen_ff[3:0];
      seen_in = seen_ff;
      if (push) begin
         if (req_chan.last_byte) begin
            seen_in = '0;
         end else if (!over) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         seen_ff   <= seen_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_ent;
         blk_ff[wr_ptr_ff] <= seen_blk[BLK_W-1:0];
      end
   end

   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = ent_ff[rd_ptr_ff];
   assign q_blk   = blk_ff[rd_ptr_ff];

endmodule

// File: hdl/aesctr_keygen.sv
// ----------------------------------------------------------------------------
// aesctr_keygen
// Key registers and an iterative AES-256 engine filling the keystream store.
// ----------------------------------------------------------------------------
module aesctr_keygen #(
   parameter int NBLK  = 16,
   parameter int BLK_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   aesctr_csr_if.sink            csr_chan,
   output logic                  wr_en,
   output logic [BLK_W-1:0]      wr_addr,
   output aesctr_pkg::block_type wr_data,
   output logic [BLK_W:0]        fill
);

   logic [63:0]           key_ff [aesctr_pkg::KEY_WORDS];
   logic                  busy_ff, busy_in;
   logic [3:0]            rnd_ff, rnd_in;
   logic [BLK_W-1:0]      gblk_ff, gblk_in;
   logic [BLK_W:0]        fill_ff, fill_in;
   aesctr_pkg::block_type st_ff, st_in;
   logic [127:0]          kp_ff, kp_in;
   logic [127:0]          kc_ff, kc_in;
   logic                  key_wr;
   logic [255:0]          key;
   aesctr_pkg::block_type ctr;
   aesctr_pkg::block_type rnd_out;
   logic [63:0]           n64;

   assign csr_chan.ready = 1'b1;
   assign key_wr = csr_chan.valid
                   && (csr_chan.index < aesctr_pkg::CSR_INDEX_W'(aesctr_pkg::KEY_WORDS));
   assign key = {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
   assign n64 = 64'(gblk_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < aesctr_pkg::KEY_WORDS; i++) begin
            key_ff[i] <= '0;
         end
      end else if (key_wr) begin
         key_ff[csr_chan.index[1:0]] <= csr_chan.data;
      end
   end

   // counter block: bytes 8 to 15 hold the block number little endian
   always_comb begin
      ctr = '0;
      for (int i = 0; i < 8; i++) begin
         ctr[7-i] = n64[8*i +: 8];
      end
      rnd_out = aesctr_pkg::enc_round(st_ff, rnd_ff == 4'(aesctr_pkg::ROUNDS)) ^ kc_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      gblk_in = gblk_ff;
      fill_in = fill_ff;
      st_in   = st_ff;
      kp_in   = kp_ff;
      kc_in   = kc_ff;
      wr_en   = 1'b0;
      if (busy_ff) begin
         if (rnd_ff == 4'd0) begin
            st_in  = ctr ^ key[255:128];
            kp_in  = key[255:128];
            kc_in  = key[127:0];
            rnd_in = 4'd1;
         end else begin
            st_in  = rnd_out;
            kp_in  = kc_ff;
            kc_in  = aesctr_pkg::next_key(kp_ff, kc_ff, rnd_ff + 4'd1);
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(aesctr_pkg::ROUNDS)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + (BLK_W+1)'(1);
               rnd_in  = 4'd0;
               if (gblk_ff == BLK_W'(NBLK-1)) begin
                  busy_in = 1'b0;
               end else begin
                  gblk_in = gblk_ff + BLK_W'(1);
               end
            end
         end
      end
      // new key: throw away the store and start over
      if (key_wr) begin
         busy_in = 1'b1;
         rnd_in  = 4'd0;
         gblk_in = '0;
         fill_in = '0;
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         rnd_ff  <= 4'd0;
         gblk_ff <= '0;
         fill_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         gblk_ff <= gblk_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      kp_ff <= kp_in;
      kc_ff <= kc_in;
   end

   assign wr_addr = gblk_ff;
   assign wr_data = rnd_out;
   assign fill    = fill_ff;

endmodule

// File: hdl/aesctr_back.sv
// ----------------------------------------------------------------------------
// aesctr_back
// Keystream store, current block register and output stage.
// ----------------------------------------------------------------------------
module aesctr_back #(
   parameter int NBLK  = 16,
   parameter int BLK_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  aesctr_pkg::entry_type q_entry,
   input  logic [BLK_W-1:0]      q_blk,
   output logic                  q_pop,
   input  logic                  wr_en,
   input  logic [BLK_W-1:0]      wr_addr,
   input  aesctr_pkg::block_type wr_data,
   input  logic [BLK_W:0]        fill,
   aesctr_rsp_if.source          rsp_chan
);

   aesctr_pkg::block_type mem [NBLK];
   aesctr_pkg::block_type ks_ff;
   logic                  s1_valid_ff, s1_valid_in;
   aesctr_pkg::entry_type s1_ff;
   logic                  head_ok;
   logic                  advance;
   logic                  rd_en;

   // a new block is only needed at block start; mid-block keeps the held one
   assign head_ok = q_entry.too_long || (q_entry.pos != 4'd0) || ({1'b0, q_blk} < fill);
   assign advance = !s1_valid_ff || rsp_chan.ready;
   assign q_pop   = q_valid && head_ok && advance;
   assign rd_en   = q_pop && !q_entry.too_long && (q_entry.pos == 4'd0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff <= '0;
      end else if (rd_en) begin
         ks_ff <= mem[q_blk];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_ff <= q_entry;
      end
   end

   assign rsp_chan.valid        = s1_valid_ff;
   assign rsp_chan.out_byte     = s1_ff.too_long ? 8'd0
                                  : (s1_ff.data_byte ^ ks_ff[4'd15 - s1_ff.pos]);
   assign rsp_chan.end_of_layer = s1_ff.last_byte;
   assign rsp_chan.too_long     = s1_ff.too_long;

endmodule

// File: hdl/aes256_ctr_layer_cipher_core.sv
// ----------------------------------------------------------------------------
// aes256_ctr_layer_cipher_core
// AES-256-CTR layer cipher: one byte in, one byte out, keystream reused per layer.
// ----------------------------------------------------------------------------
// bytes pass front queue and output registers; one byte per cycle unless stalled
// keystream blocks 0..ceil(MAX_LAYER_BYTES/16)-1 come from an iterative AES engine
// block n's first byte waits until block n is stored after reset or a key write
// reset clears key registers, layer counters and the keystream store fill count
module aes256_ctr_layer_cipher_core #(
   parameter int MAX_LAYER_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   aesctr_req_if.sink   req_chan,
   aesctr_rsp_if.source rsp_chan,
   aesctr_csr_if.sink   csr_chan
);

   localparam int NBLK   = (MAX_LAYER_BYTES + 15) / 16;
   localparam int BLK_W  = (NBLK > 1) ? $clog2(NBLK) : 1;
   localparam int SEEN_W = $clog2(MAX_LAYER_BYTES + 1);

   logic                  q_valid;
   aesctr_pkg::entry_type q_entry;
   logic [BLK_W-1:0]      q_blk;
   logic                  q_pop;
   logic                  wr_en;
   logic [BLK_W-1:0]      wr_addr;
   aesctr_pkg::block_type wr_data;
   logic [BLK_W:0]        fill;

   aesctr_front #(
      .MAX_LAYER_BYTES (MAX_LAYER_BYTES),
      .SEEN_W          (SEEN_W),
      .BLK_W           (BLK_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_blk    (q_blk),
      .q_pop    (q_pop)
   );

   aesctr_keygen #(
      .NBLK  (NBLK),
      .BLK_W (BLK_W)
   ) u_keygen (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .fill     (fill)
   );

   aesctr_back #(
      .NBLK  (NBLK),
      .BLK_W (BLK_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_blk    (q_blk),
      .q_pop    (q_pop),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .fill     (fill),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: dv/aesctr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aesctr_checker
// Watches the byte, result and key channels of the layer cipher, predicts
// each result with its own AES-256-CTR keystream and compares field by field.
// ----------------------------------------------------------------------------
module aesctr_checker #(
   parameter int LAYER_LIMIT = 256
) (
   input  logic   clock,
   input  logic   reset,
   aesctr_req_if  req_chan,
   aesctr_rsp_if  rsp_chan,
   aesctr_csr_if  csr_chan,
   output int     fail_count,
   output int     pending
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_layer;
      logic       too_long;
   } cipher_result_t;

   cipher_result_t result_queue[$];
   logic [63:0]    key_reg[aesctr_pkg::KEY_WORDS];
   logic [127:0]   keystream;
   int unsigned    block_count;
   int unsigned    byte_index;
   int unsigned    layer_bytes;
   int             mismatch_count;

   assign fail_count = mismatch_count;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of key and block sits at bits [255-8i] and [127-8i]
   function automatic logic [127:0] aes256_block(input logic [255:0] key,
                                                 input logic [127:0] pt);
      logic [7:0]   rk[240];
      logic [7:0]   s[16];
      logic [7:0]   t[16];
      logic [7:0]   w[4];
      logic [7:0]   f, a0, a1, a2, a3, x;
      logic [127:0] ct;
      for (int i = 0; i < 32; i++) rk[i] = key[255-8*i -: 8];
      for (int i = 8; i < 60; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if (i % 8 == 0) begin
            f    = w[0];
            w[0] = aesctr_pkg::SBOX[w[1]] ^ (8'h01 << ((i / 8) - 1));
            w[1] = aesctr_pkg::SBOX[w[2]];
            w[2] = aesctr_pkg::SBOX[w[3]];
            w[3] = aesctr_pkg::SBOX[f];
         end else if (i % 8 == 4) begin
            for (int j = 0; j < 4; j++) w[j] = aesctr_pkg::SBOX[w[j]];
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-8)+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
      for (int r = 1; r <= aesctr_pkg::ROUNDS; r++) begin
         for (int i = 0; i < 16; i++) t[i] = aesctr_pkg::SBOX[s[i]];
         for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++) s[i+4*c] = t[i+4*((c+i)%4)];
         if (r != aesctr_pkg::ROUNDS) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c];
               a1 = s[4*c+1];
               a2 = s[4*c+2];
               a3 = s[4*c+3];
               x  = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ x ^ gf_double(a0 ^ a1);
               s[4*c+1] = a1 ^ x ^ gf_double(a1 ^ a2);
               s[4*c+2] = a2 ^ x ^ gf_double(a2 ^ a3);
               s[4*c+3] = a3 ^ x ^ gf_double(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[16*r+i];
      end
      for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
      return ct;
   endfunction

   function automatic cipher_result_t cipher_byte(input logic [7:0] data, input logic last);
      cipher_result_t res;
      logic [127:0]   ctr;
      res = '0;
      res.end_of_layer = last;
      if (layer_bytes >= LAYER_LIMIT) begin
         res.too_long = 1'b1;
      end else begin
         // new keystream block at each block boundary, from the current key
         if (byte_index == 0) begin
            ctr = '0;
            for (int k = 0; k < 4; k++) ctr[127-8*(8+k) -: 8] = block_count[8*k +: 8];
            keystream = aes256_block({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}, ctr);
         end
         res.out_byte = data ^ keystream[127-8*byte_index -: 8];
         byte_index = (byte_index + 1) % aesctr_pkg::BLOCK_BYTES;
         if (byte_index == 0) block_count++;
         layer_bytes++;
      end
      if (last) begin
         block_count = 0;
         byte_index  = 0;
         layer_bytes = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      cipher_result_t want;
      cipher_result_t got;
      if (reset) begin
         result_queue.delete();
         for (int i = 0; i < aesctr_pkg::KEY_WORDS; i++) key_reg[i] = '0;
         keystream   = '0;
         block_count = 0;
         byte_index  = 0;
         layer_bytes = 0;
         mismatch_count = 0;
      end else begin
         if (csr_chan.valid && csr_chan.ready && csr_chan.index < aesctr_pkg::KEY_WORDS)
            key_reg[csr_chan.index] = csr_chan.data;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.out_byte, rsp_chan.end_of_layer, rsp_chan.too_long};
            if (result_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result transfer %h/%b/%b", $realtime,
                           got.out_byte, got.end_of_layer, got.too_long);
            end else begin
               want = result_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch out_byte %h/%h end_of_layer %b/%b too_long %b/%b",
                              $realtime, want.out_byte, got.out_byte, want.end_of_layer,
                              got.end_of_layer, want.too_long, got.too_long);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            result_queue.push_back(cipher_byte(req_chan.data_byte, req_chan.last_byte));
      end
      pending = result_queue.size();
   end

endmodule

// File: dv/tb_aes256_ctr_layer_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes256_ctr_layer_cipher_core
// Drives byte layers and key writes into the layer cipher with random gaps
// and result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aes256_ctr_layer_cipher_core;

   localparam int KEY_IDX_UNUSED = aesctr_pkg::KEY_WORDS;
   localparam int KEY_IDX_TOP    = (1 << aesctr_pkg::CSR_INDEX_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   logic quiet_mode = 1'b0;
   int   rsp_hold = 0;

   aesctr_req_if req_chan();
   aesctr_rsp_if rsp_chan();
   aesctr_csr_if csr_chan();

   aes256_ctr_layer_cipher_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   aesctr_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data  = '0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_hold <= pick_gap();
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.last_byte <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_layer(input int len, input int fill_kind);
      logic [7:0] d;
      for (int i = 0; i < len; i++) begin
         case (fill_kind)
            0:       d = 8'h00;
            1:       d = 8'hff;
            2:       d = i[0] ? 8'haa : 8'h55;
            default: d = 8'($urandom_range(0, 255));
         endcase
         send_byte(d, i == len - 1);
      end
   endtask

   // valid stays high across back-to-back writes; the caller drops it
   task automatic write_key(input int idx, input logic [63:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx[aesctr_pkg::CSR_INDEX_W-1:0];
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
   endtask

   // drain the pending results, then load a new key
   task automatic change_key(input int kind);
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      for (int k = 0; k < aesctr_pkg::KEY_WORDS; k++) begin
         case (kind)
            0:       write_key(k, 64'h0);
            1:       write_key(k, '1);
            default: write_key(k, {$urandom, $urandom});
         endcase
      end
      write_key(KEY_IDX_UNUSED, {$urandom, $urandom});
      write_key(KEY_IDX_TOP, '1);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int sent;
      int len;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme keys and data, short and block-crossing layers
      change_key(0);
      send_layer(1, 0);
      send_layer(3, 1);
      send_layer(17, 2);
      change_key(1);
      send_layer(1, 1);
      send_layer(2, 0);

      // random layers; a layer may straddle a key change
      sent = 0;
      for (int phase = 0; phase < 6; phase++) begin
         change_key(2);
         quiet_mode = (phase == 2);
         if (phase == 3) begin
            send_layer(260, 3);  // overlong, the bytes past the limit flagged too_long
            sent += 260;
         end
         while (sent < 70 * (phase + 1)) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            send_layer(len, 3);
            sent += len;
         end
         // leave part of a layer open across the key change
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b0);
         sent += 2;
      end
      change_key(2);
      send_layer(5, 3);
      req_chan.valid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
